// ----- rtl/core/fds_pkg.sv -----
// shared types and constants of the format decimal substitution unit
`timescale 1ns / 1ps

package fds_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ARG_W  = 31;
  localparam int unsigned BCD_DIG_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PCT  = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_CONV = 8'h64;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

  // double dabble: a digit of five or more gets three added before the shift
  localparam logic [BCD_DIG_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [BCD_DIG_W-1:0] BCD_ADJ     = 4'd3;

  typedef enum logic [1:0] {
    B2D_IDLE,
    B2D_CONV,
    B2D_SKIP,
    B2D_EMIT
  } b2d_state_e;

  // status of the converter as seen by the top level
  typedef struct packed {
    logic                 busy;
    logic                 valid;
    logic                 last;
    logic [BCD_DIG_W-1:0] digit;
  } fds_dig_t;

endpackage

// ----- rtl/core/fds_b2d.sv -----
// bit-serial binary to decimal converter with serial digit output
`timescale 1ns / 1ps

module fds_b2d #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fds_pkg::ARG_W-1:0]  arg_i,
  input  logic                       take_i,
  output fds_pkg::fds_dig_t          dig_o
);
  import fds_pkg::*;

  localparam int unsigned BcdW    = MAX_DIGITS * BCD_DIG_W;
  localparam int unsigned DigCntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BitCntW = $clog2(ARG_W);

  b2d_state_e state_q, state_d;

  logic [ARG_W-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BcdW-1:0]    bcd_adj;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic [BCD_DIG_W-1:0] top_digit;
  logic               top_zero;
  logic               last_digit;

  assign top_digit  = bcd_q[BcdW-1 -: BCD_DIG_W];
  assign top_zero   = (top_digit == '0);
  assign last_digit = (dig_cnt_q == DigCntW'(1));

  // add-3 correction on every digit, all in parallel
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[i*BCD_DIG_W +: BCD_DIG_W] >= BCD_ADJ_MIN) begin
        bcd_adj[i*BCD_DIG_W +: BCD_DIG_W] = bcd_q[i*BCD_DIG_W +: BCD_DIG_W] + BCD_ADJ;
      end else begin
        bcd_adj[i*BCD_DIG_W +: BCD_DIG_W] = bcd_q[i*BCD_DIG_W +: BCD_DIG_W];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B2D_IDLE: begin
        if (start_i) state_d = B2D_CONV;
      end
      B2D_CONV: begin
        if (bit_cnt_q == '0) state_d = B2D_SKIP;
      end
      B2D_SKIP: begin
        if (!top_zero || last_digit) state_d = B2D_EMIT;
      end
      B2D_EMIT: begin
        if (take_i && last_digit) state_d = B2D_IDLE;
      end
      default: state_d = B2D_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    dig_o.busy  = 1'b1;
    dig_o.valid = 1'b0;
    dig_o.last  = last_digit;
    dig_o.digit = top_digit;
    case (state_q)
      B2D_IDLE: begin
        dig_o.busy = 1'b0;
        if (start_i) begin
          bin_d     = arg_i;
          bcd_d     = '0;
          bit_cnt_d = BitCntW'(ARG_W - 1);
        end
      end
      B2D_CONV: begin
        // carry out of the top digit is dropped, keeping the low digits only
        bcd_d     = {bcd_adj[BcdW-2:0], bin_q[ARG_W-1]};
        bin_d     = bin_q << 1;
        bit_cnt_d = bit_cnt_q - BitCntW'(1);
        dig_cnt_d = DigCntW'(MAX_DIGITS);
      end
      B2D_SKIP: begin
        // drop leading zeros, always keep one digit
        if (top_zero && !last_digit) begin
          bcd_d     = bcd_q << BCD_DIG_W;
          dig_cnt_d = dig_cnt_q - DigCntW'(1);
        end
      end
      B2D_EMIT: begin
        dig_o.valid = 1'b1;
        if (take_i) begin
          bcd_d     = bcd_q << BCD_DIG_W;
          dig_cnt_d = dig_cnt_q - DigCntW'(1);
        end
      end
      default: begin
        dig_o.busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B2D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
  end

endmodule

// ----- rtl/core/format_decimal_substitution_unit.sv -----
// format string streamer that substitutes %d with the decimal argument
//
//  channel  | dir | tdata                                  | tlast | tuser
//  s_axis   | in  | [7:0] fmt_char, [38:8] arg_value       | -     | -
//  m_axis   | out | [7:0] out_char                         | last  | bad_spec
//
//  a literal byte gives one transfer
//  %d runs a bit-serial double dabble over the argument bits, then drops one
//  leading zero per step and settles on the first digit, then gives one digit per
//  step while m_axis takes them; input is held off meanwhile
//  reset clears the pending and failed flags and empties the output register
//  a stalled m_axis holds the output register and with it the input side
`timescale 1ns / 1ps

module format_decimal_substitution_unit #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // fmt_char, arg_value, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_char
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // bad_spec
);
  import fds_pkg::*;

  logic [CHAR_W-1:0] fmt_char;
  logic [ARG_W-1:0]  arg_value;
  logic in_fire;
  logic out_free;
  logic start;
  logic take;
  fds_dig_t dig;

  logic pending_q, pending_d;
  logic failed_q, failed_d;
  logic m_valid_q, m_valid_d;
  logic [CHAR_W-1:0] m_char_q, m_char_d;
  logic m_last_q, m_last_d;
  logic m_bad_q, m_bad_d;

  assign fmt_char  = s_axis_tdata[CHAR_W-1:0];
  assign arg_value = s_axis_tdata[CHAR_W +: ARG_W];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !dig.busy && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign take          = dig.valid && out_free;

  fds_b2d #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_b2d (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .arg_i  (arg_value),
    .take_i (take),
    .dig_o  (dig)
  );

  always_comb begin
    pending_d = pending_q;
    failed_d  = failed_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;
    m_bad_d   = m_bad_q;
    start     = 1'b0;
    if (in_fire) begin
      if (fmt_char == CHAR_NUL) begin
        if (pending_q && !failed_q) begin
          m_valid_d = 1'b1;
          m_char_d  = CHAR_NUL;
          m_last_d  = 1'b1;
          m_bad_d   = 1'b1;
        end
        pending_d = 1'b0;
        failed_d  = 1'b0;
      end else if (failed_q) begin
        // output suppressed until the end of the string
      end else if (pending_q) begin
        pending_d = 1'b0;
        if (fmt_char == CHAR_CONV) begin
          start = 1'b1;
        end else begin
          failed_d  = 1'b1;
          m_valid_d = 1'b1;
          m_char_d  = CHAR_NUL;
          m_last_d  = 1'b1;
          m_bad_d   = 1'b1;
        end
      end else if (fmt_char == CHAR_PCT) begin
        pending_d = 1'b1;
      end else begin
        m_valid_d = 1'b1;
        m_char_d  = fmt_char;
        m_last_d  = 1'b1;
        m_bad_d   = 1'b0;
      end
    end else if (take) begin
      m_valid_d = 1'b1;
      m_char_d  = CHAR_ZERO | CHAR_W'(dig.digit);
      m_last_d  = dig.last;
      m_bad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      failed_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
      failed_q  <= failed_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_char_q <= m_char_d;
    m_last_q <= m_last_d;
    m_bad_q  <= m_bad_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_char_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_bad_q;

  // a conversion only runs with both string flags clear
  a_busy_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig.busy |-> (!pending_q && !failed_q))
    else $error("converter busy with a string flag set");

  // the converter only starts from an accepted transfer
  a_busy_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dig.busy) |-> $past(in_fire))
    else $error("converter started without an input transfer");

  // an error result carries a zero character and ends its burst
  a_bad_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_bad_q) |-> (m_char_q == CHAR_NUL && m_last_q))
    else $error("malformed error result");

endmodule
